>>> design/blzd_pkg.sv
// ----------------------------------------------------------------------------
// blzd_pkg
// Shared constants and controller/datapath handshake types for the backward
// LZ decompressor.
// ----------------------------------------------------------------------------
package blzd_pkg;

    // default history depth, in bytes
    localparam int unsigned HistoryDepthDefault = 8192;

    // token format
    localparam logic [3:0] FlagsPerByte = 4'd8;
    localparam int unsigned LenBias  = 3;
    localparam int unsigned DispBias = 2;  // distance bias of 3, minus the step to the new byte
    localparam int unsigned CountW   = 5;  // longest copy is 15 + 3 bytes
    localparam int unsigned DispW    = 12;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;  // input item accepted this cycle
        logic copy_step;  // move one copied byte into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ref_low;    // next input byte is the low half of a reference
        logic out_free;   // output register can take a result this cycle
        logic copy_last;  // one copied byte left
    } status_t;

endpackage

>>> design/blzd_ctrl.sv
// ----------------------------------------------------------------------------
// blzd_ctrl
// Controller: gates input acceptance and sequences reference copies.
// ----------------------------------------------------------------------------
module blzd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  blzd_pkg::status_t status,
    output blzd_pkg::cmd_t    cmd
);
    import blzd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.take_item = 1'b0;
        cmd.copy_step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready      = status.out_free;
                cmd.take_item = s_tvalid && status.out_free;
                if (cmd.take_item && status.ref_low)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = status.out_free;
                if (status.out_free && status.copy_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/blzd_datapath.sv
// ----------------------------------------------------------------------------
// blzd_datapath
// Token decoder registers, history memory with write position, and the
// output register.
// ----------------------------------------------------------------------------
module blzd_datapath #(
    parameter int unsigned HISTORY_DEPTH = blzd_pkg::HistoryDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        packed_byte,
    input  logic              final_byte,
    input  blzd_pkg::cmd_t    cmd,
    output blzd_pkg::status_t status,
    input  logic              m_tready,
    output logic              out_valid,
    output logic [7:0]        plain_byte,
    output logic              has_byte,
    output logic              truncated,
    output logic              end_of_output
);
    import blzd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] DepthW = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LastAddr = AW'(HISTORY_DEPTH - 1);

    // history store, no reset
    logic [7:0] hist_mem [HISTORY_DEPTH];
    logic [7:0] rd_data_reg;

    // token and copy state
    logic [AW-1:0]     wp_reg, wp_next;
    logic [7:0]        flags_reg, flags_next;
    logic [3:0]        left_reg, left_next;
    logic              await_reg, await_next;
    logic [7:0]        high_reg, high_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [DispW-1:0]  disp_reg, disp_next;
    logic              fin_reg, fin_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_has_reg, out_has_next;
    logic       out_trunc_reg, out_trunc_next;
    logic       out_end_reg, out_end_next;

    logic             out_free;
    logic             copy_last;
    logic [AW-1:0]    wp_dec;
    logic [DispW-1:0] disp_in;
    logic [DispW-1:0] rd_disp;
    logic [AW-1:0]    rd_base;
    logic [AW:0]      rd_sum;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [7:0]       wr_data;

    assign out_free  = !out_valid_reg || m_tready;
    assign copy_last = (count_reg == CountW'(1));

    assign status.ref_low   = await_reg;
    assign status.out_free  = out_free;
    assign status.copy_last = copy_last;

    // new bytes go one below the most recent one, with wrap
    assign wp_dec = (wp_reg == '0) ? LastAddr : wp_reg - 1'b1;

    // copy source: most recent position plus biased distance, with wrap
    assign disp_in = {high_reg[3:0], packed_byte};
    assign rd_disp = cmd.take_item ? disp_in : disp_reg;
    assign rd_base = cmd.take_item ? wp_reg : wp_dec;
    assign rd_sum  = {1'b0, rd_base} + (AW + 1)'(rd_disp) + (AW + 1)'(DispBias);
    assign rd_addr = (rd_sum >= DepthW) ? AW'(rd_sum - DepthW) : rd_sum[AW-1:0];
    assign rd_en   = (cmd.take_item && await_reg) || (cmd.copy_step && !copy_last);

    // token decode and copy stepping
    always_comb
    begin
        wp_next        = wp_reg;
        flags_next     = flags_reg;
        left_next      = left_reg;
        await_next     = await_reg;
        high_next      = high_reg;
        count_next     = count_reg;
        disp_next      = disp_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_trunc_next = out_trunc_reg;
        out_end_next   = out_end_reg;
        wr_en          = 1'b0;
        wr_data        = packed_byte;

        if (cmd.take_item)
        begin
            if (await_reg)
            begin
                // low half: latch the reference and read the first copy source
                await_next = 1'b0;
                disp_next  = disp_in;
                count_next = CountW'(high_reg[7:4]) + CountW'(LenBias);
                fin_next   = final_byte;
            end
            else if (left_reg == '0)
            begin
                // flag byte
                flags_next = packed_byte;
                left_next  = FlagsPerByte;
                if (final_byte)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_has_next   = 1'b0;
                    out_trunc_next = 1'b0;
                    out_end_next   = 1'b1;
                end
            end
            else
            begin
                flags_next = {flags_reg[6:0], 1'b0};
                left_next  = left_reg - 1'b1;
                if (!flags_reg[7])
                begin
                    // literal
                    wr_en          = 1'b1;
                    wp_next        = wp_dec;
                    out_valid_next = 1'b1;
                    out_byte_next  = packed_byte;
                    out_has_next   = 1'b1;
                    out_trunc_next = 1'b0;
                    out_end_next   = final_byte;
                end
                else
                begin
                    // high half of a reference
                    high_next  = packed_byte;
                    await_next = 1'b1;
                    if (final_byte)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_has_next   = 1'b0;
                        out_trunc_next = 1'b1;
                        out_end_next   = 1'b1;
                    end
                end
            end

            // end of stream: back to expecting a flag byte
            if (final_byte)
            begin
                flags_next = '0;
                left_next  = '0;
                await_next = 1'b0;
                high_next  = '0;
            end
        end
        else if (cmd.copy_step)
        begin
            wr_en          = 1'b1;
            wr_data        = rd_data_reg;
            wp_next        = wp_dec;
            count_next     = count_reg - 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            out_has_next   = 1'b1;
            out_trunc_next = 1'b0;
            out_end_next   = fin_reg && copy_last;
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wp_dec] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            flags_reg     <= '0;
            left_reg      <= '0;
            await_reg     <= 1'b0;
            high_reg      <= '0;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            flags_reg     <= flags_next;
            left_reg      <= left_next;
            await_reg     <= await_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        disp_reg      <= disp_next;
        out_byte_reg  <= out_byte_next;
        out_has_reg   <= out_has_next;
        out_trunc_reg <= out_trunc_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid     = out_valid_reg;
    assign plain_byte    = out_byte_reg;
    assign has_byte      = out_has_reg;
    assign truncated     = out_trunc_reg;
    assign end_of_output = out_end_reg;

endmodule

>>> design/backward_lz_decompressor_unit.sv
// ----------------------------------------------------------------------------
// backward_lz_decompressor_unit
// Backward LZ decompressor: compressed bytes in, plain bytes out, both in
// descending address order.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one compressed byte per item, s_tlast marking the last
//   byte of the payload. m_* channel gives one result per item: the plain
//   byte, tuser flags has_byte and truncated, and tlast on the stream end.
//   Flag bytes and reference high bytes give no result except at stream end,
//   where an empty result (has_byte low) closes the stream.
// Sequencing:
//   A result is registered as its item is taken. Flag, literal and high
//   bytes are taken one per cycle; a reference low byte starts a copy of 3
//   to 18 bytes, one byte per cycle, set by the single read port of the
//   history memory. Both rates need a free output register; input is held off
//   during the copy, whose first byte is read as the low byte is taken.
// Reset:
//   Token state clears to "expect flag byte", write position to zero. The
//   history memory is not cleared; a copy must only reach written bytes.
// Stall:
//   While m_tready is low with a result pending, input and copy both wait.
// ----------------------------------------------------------------------------
module backward_lz_decompressor_unit #(
    parameter int unsigned HISTORY_DEPTH = blzd_pkg::HistoryDepthDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    // compressed byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] packed_byte
    input  logic       s_tlast,   // final_byte
    // decompressed byte stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] plain_byte
    output logic [1:0] m_tuser,   // [0] has_byte, [1] truncated
    output logic       m_tlast    // end_of_output
);
    import blzd_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    has_byte;
    logic    truncated;

    // controller
    blzd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    blzd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .packed_byte   (s_tdata),
        .final_byte    (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .plain_byte    (m_tdata),
        .has_byte      (has_byte),
        .truncated     (truncated),
        .end_of_output (m_tlast)
    );

    assign m_tuser = {truncated, has_byte};

endmodule

>>> design/blzd_checker.sv
// ----------------------------------------------------------------------------
// blzd_checker
// Port-level checks on the decompressor output stream.
// ----------------------------------------------------------------------------
module blzd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty result only closes a stream
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
        else $error("empty result not at stream end");

    // truncation is flagged only on an empty result
    a_trunc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("truncated result carries a byte");

    // final byte of a payload on an idle output is followed by a result or a copy
    a_final_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready || m_tvalid)
        else $error("stream end produced neither result nor copy");

endmodule

bind backward_lz_decompressor_unit blzd_checker u_blzd_checker (.*);

>>> tb/sv/backward_lz_decompressor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backward_lz_decompressor_unit_tb
// Self-checking bench for the backward LZ decompressor. Compressed streams
// are built so that every back reference lands on bytes already produced,
// fed through a stream driver with random gaps, and every plain byte and
// end result is checked against a cycle-free decode kept in the bench.
// ----------------------------------------------------------------------------
module backward_lz_decompressor_unit_tb;

    import blzd_pkg::*;

    localparam int HIST        = HistoryDepthDefault;
    localparam int AW          = $clog2(HIST);
    localparam int MAX_DISP    = 4095;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 18;

    // how a generated stream is closed
    typedef enum int {
        END_LITERAL,
        END_LOW,
        END_HIGH,
        END_FLAG
    } stream_end_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_item_t;

    typedef struct packed {
        logic [7:0] plain;
        logic       has;
        logic       trunc;
        logic       last;
    } plain_item_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // stimulus and scoreboard
    packed_item_t packed_q[$];
    plain_item_t  plain_due_q[$];
    packed_item_t nxt_item;
    plain_item_t  due;
    logic         in_taken    = 1'b0;
    int           n_queued    = 0;
    int           n_taken     = 0;
    int           err_count   = 0;
    int           idle_cycles = 0;
    int           gen_count   = 0;   // plain bytes produced since reset
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;

    // decoder state mirrored in the bench
    logic [7:0]    hist [HIST];
    logic [AW-1:0] wr_pos    = '0;
    logic [7:0]    tok_flags = 8'h00;
    logic [3:0]    tok_left  = 4'd0;
    logic          want_low  = 1'b0;
    logic [7:0]    hi_half   = 8'h00;

    backward_lz_decompressor_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        err_count++;
    endtask

    // expected plain results for one accepted compressed item
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        int            n0;
        int            len;
        int            i;
        logic [11:0]   disp;
        logic [AW-1:0] src;
        logic [7:0]    v;
        logic          is_ref;
        n0 = plain_due_q.size();
        if (want_low)
        begin
            disp     = {hi_half[3:0], b};
            len      = int'(hi_half[7:4]) + LenBias;
            want_low = 1'b0;
            for (i = 0; i < len; i++)
            begin
                src          = wr_pos + AW'(disp) + AW'(DispBias);
                v            = hist[src];
                wr_pos       = wr_pos - 1'b1;
                hist[wr_pos] = v;
                plain_due_q.push_back('{v, 1'b1, 1'b0, 1'b0});
            end
        end
        else if (tok_left == 4'd0)
        begin
            tok_flags = b;
            tok_left  = FlagsPerByte;
            if (fin)
                plain_due_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
        end
        else
        begin
            is_ref    = tok_flags[7];
            tok_flags = {tok_flags[6:0], 1'b0};
            tok_left  = tok_left - 1'b1;
            if (!is_ref)
            begin
                wr_pos       = wr_pos - 1'b1;
                hist[wr_pos] = b;
                plain_due_q.push_back('{b, 1'b1, 1'b0, 1'b0});
            end
            else
            begin
                hi_half  = b;
                want_low = 1'b1;
                if (fin)
                    plain_due_q.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
            end
        end
        // stream end: tag the last result and go back to expecting a flag byte
        if (fin)
        begin
            if (plain_due_q.size() > n0)
                plain_due_q[plain_due_q.size() - 1].last = 1'b1;
            tok_flags = 8'h00;
            tok_left  = 4'd0;
            want_low  = 1'b0;
            hi_half   = 8'h00;
        end
    endtask

    task automatic push_item(input logic [7:0] data, input logic last);
        packed_q.push_back('{data, last});
        n_queued++;
    endtask

    // one compressed stream; references only reach bytes already produced
    task automatic gen_stream(input int n_tok, input stream_end_e kind,
                              input int ref_pct, input bit long_ref);
        packed_item_t body[$];
        logic [7:0]   flags;
        logic [11:0]  disp;
        int           done;
        int           grp;
        int           i;
        int           len;
        int           dmax;
        bit           is_last;
        bit           want_ref;
        done = 0;
        if (kind == END_FLAG)
            n_tok = (n_tok + 7) / 8 * 8;
        while (done < n_tok)
        begin
            grp   = (n_tok - done > 8) ? 8 : n_tok - done;
            flags = 8'($urandom);
            body.delete();
            for (i = 0; i < grp; i++)
            begin
                is_last  = (done + i == n_tok - 1) && (kind != END_FLAG);
                want_ref = ($urandom_range(99) < ref_pct);
                if (is_last && kind == END_LITERAL)
                    want_ref = 1'b0;
                if (is_last && (kind == END_LOW || kind == END_HIGH))
                    want_ref = 1'b1;
                // a full reference needs at least three bytes behind it
                if (want_ref && gen_count < 3 && !(is_last && kind == END_HIGH))
                    want_ref = 1'b0;
                flags[7 - i] = want_ref;
                if (!want_ref)
                begin
                    body.push_back('{8'($urandom), is_last});
                    gen_count++;
                end
                else if (is_last && kind == END_HIGH)
                    body.push_back('{8'($urandom), 1'b1});
                else
                begin
                    len  = long_ref ? 15 : $urandom_range(15);
                    dmax = gen_count - 3;
                    if (dmax > MAX_DISP)
                        dmax = MAX_DISP;
                    case ($urandom_range(3))
                        0:       disp = 12'd0;
                        1:       disp = 12'(dmax);
                        default: disp = 12'($urandom_range(dmax));
                    endcase
                    body.push_back('{{4'(len), disp[11:8]}, 1'b0});
                    body.push_back('{disp[7:0], is_last});
                    gen_count += len + LenBias;
                end
            end
            push_item(flags, 1'b0);
            foreach (body[k])
                push_item(body[k].data, body[k].last);
            done += grp;
        end
        if (kind == END_FLAG)
            push_item(8'($urandom), 1'b1);
    endtask

    // hold the sender until every item is taken and every result is back
    task automatic wait_drained();
        while (!(n_taken == n_queued && plain_due_q.size() == 0))
            @(posedge clk);
    endtask

    // stream driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (packed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt_item = packed_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt_item.data;
                s_tlast  <= nxt_item.last;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor: check results, then decode newly taken items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (plain_due_q.size() == 0)
                    report_mismatch($sformatf("unexpected result data %02h user %b last %b",
                                              m_tdata, m_tuser, m_tlast));
                else
                begin
                    due = plain_due_q.pop_front();
                    if (m_tdata !== due.plain || m_tuser[0] !== due.has
                        || m_tuser[1] !== due.trunc || m_tlast !== due.last)
                        report_mismatch($sformatf(
                            "data %02h/%02h has %b/%b trunc %b/%b last %b/%b (got/exp)",
                            m_tdata, due.plain, m_tuser[0], due.has,
                            m_tuser[1], due.trunc, m_tlast, due.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                n_taken++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        in_taken <= rst_n && s_tvalid && s_tready;
    end

    // watchdog
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("backward_lz_decompressor_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        stream_end_e kind;
        int          phase;
        int          start;
        int          n_tok;

        // empty stream: final on the very first flag byte
        push_item(8'h00, 1'b1);
        // eight literals at the byte extremes, then final on a flag byte
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h55, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h7F, 1'b0);
        push_item(8'hFE, 1'b0);
        push_item(8'hFF, 1'b1);
        // longest copy at the nearest distance, shortest copy at the farthest
        // written byte, then the stream ends on a reference high byte
        push_item(8'hE0, 1'b0);
        push_item(8'hF0, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h17, 1'b0);
        push_item(8'hFF, 1'b1);
        // literal then a reference whose low byte ends the stream
        push_item(8'h40, 1'b0);
        push_item(8'h3C, 1'b0);
        push_item(8'h20, 1'b0);
        push_item(8'h05, 1'b1);
        // stream ending on a literal
        push_item(8'h00, 1'b0);
        push_item(8'hC3, 1'b1);
        gen_count = 36;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // one stream of back-to-back longest copies to build up history
        gen_stream(8, END_LOW, 100, 1'b1);
        wait_drained();

        // random streams under each idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1:       begin tx_idle_pct = 62; rx_idle_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_idle_pct = 62; end
                default: begin tx_idle_pct = 36; rx_idle_pct = 36; end
            endcase
            start = n_queued;
            while (n_queued - start < PHASE_ITEMS)
            begin
                case ($urandom_range(9))
                    0:          kind = END_HIGH;
                    1:          kind = END_FLAG;
                    2, 3, 4, 5: kind = END_LOW;
                    default:    kind = END_LITERAL;
                endcase
                n_tok = (kind == END_FLAG) ? 8 * $urandom_range(2) : $urandom_range(1, 14);
                gen_stream(n_tok, kind, 50, 1'b0);
            end
            wait_drained();
        end

        // let any stray result show up before the verdict
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("backward_lz_decompressor_unit_tb OK");
        else
            $display("backward_lz_decompressor_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
design/blzd_pkg.sv
design/blzd_ctrl.sv
design/blzd_datapath.sv
design/backward_lz_decompressor_unit.sv
design/blzd_checker.sv
tb/sv/backward_lz_decompressor_unit_tb.sv
